// ===== hdl/uspd_pkg.sv =====
// Shared types and constants for the upstroke slope peak detector.
package uspd_pkg;

   localparam int SLOPE_BITS    = 32;
   localparam int OUT_TIME_BITS = 32;
   localparam int FRAC_BITS     = 8;

   typedef logic signed [SLOPE_BITS-1:0] slope_type;
   typedef logic [OUT_TIME_BITS-1:0]     peak_time_type;

   localparam slope_type SLOPE_MAX = 32'sh7FFF_FFFF;
   localparam slope_type SLOPE_MIN = 32'sh8000_0000;

   // Magnitude limit of a negative quotient before it clamps to SLOPE_MIN.
   localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;
   localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;

endpackage

// ===== hdl/uspd_if.sv =====
// Valid/ready channel interfaces for sample items and peak items.
interface uspd_req_if #(
   parameter int TIME_BITS = 32,
   parameter int VOLT_BITS = 16
);
   logic                        valid;
   logic                        ready;
   logic [TIME_BITS-1:0]        sample_time;
   logic signed [VOLT_BITS-1:0] potential;

   modport source (output valid, output sample_time, output potential, input ready);
   modport sink (input valid, input sample_time, input potential, output ready);
endinterface

interface uspd_rsp_if
   import uspd_pkg::*;
;
   logic          valid;
   logic          ready;
   slope_type     peak_slope;
   peak_time_type peak_time;

   modport source (output valid, output peak_slope, output peak_time, input ready);
   modport sink (input valid, input peak_slope, input peak_time, output ready);
endinterface

// ===== hdl/upstroke_slope_peak_detector.sv =====
// Upstroke slope peak detector: each sample item after the first gives the slope
// (256 * dV) / dt, found by a restoring divider that yields one quotient bit per
// cycle over VOLT_BITS + 9 quotient bits; a new item is not accepted until the
// block is through with the last one. The first item and items with a zero or
// backward time step skip the divider. A slope above both neighbors is a
// candidate; a positive candidate above both neighboring candidates is
// delivered as a peak item with the start time of its interval (low 32 bits). A
// finished peak waits in an output register while new samples are taken; the
// block stalls only when a second peak is ready before the first has been taken.
module upstroke_slope_peak_detector
   import uspd_pkg::*;
#(
   parameter int TIME_BITS = 32,
   parameter int VOLT_BITS = 16
) (
   input logic      clock,
   input logic      reset,
   uspd_req_if.sink req,
   uspd_rsp_if.source rsp
);

   localparam int NUM_BITS = VOLT_BITS + 1 + FRAC_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIN,
      ST_EVAL
   } state_type;

   state_type                   state_ff, state_in;
   logic [TIME_BITS-1:0]        last_time_ff, last_time_in;
   logic signed [VOLT_BITS-1:0] last_pot_ff, last_pot_in;
   logic [TIME_BITS-1:0]        t_ff, t_in;
   logic signed [VOLT_BITS-1:0] v_ff, v_in;
   logic                        neg_ff, neg_in;
   logic                        maxed_ff, maxed_in;
   slope_type                   slope_ff, slope_in;
   slope_type                   slope_win_ff [2];
   slope_type                   slope_win_in [2];
   peak_time_type               slope_tw_ff [2];
   peak_time_type               slope_tw_in [2];
   logic [1:0]                  slope_fill_ff, slope_fill_in;
   slope_type                   cand_win_ff [2];
   slope_type                   cand_win_in [2];
   peak_time_type               cand_tw_ff [2];
   peak_time_type               cand_tw_in [2];
   logic [1:0]                  cand_fill_ff, cand_fill_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   slope_type                   rsp_slope_ff, rsp_slope_in;
   peak_time_type               rsp_time_ff, rsp_time_in;

   logic                        div_start;
   logic                        div_done;
   logic [NUM_BITS-1:0]         div_quot;
   logic signed [VOLT_BITS:0]   dv;
   logic [VOLT_BITS:0]          mag;
   logic [TIME_BITS-1:0]        dt;
   logic [63:0]                 q_wide;
   logic                        slope_hit;
   logic                        cand_emit;
   logic                        out_blocked;

   assign dv  = $signed({req.potential[VOLT_BITS-1], req.potential})
              - $signed({last_pot_ff[VOLT_BITS-1], last_pot_ff});
   assign mag = dv[VOLT_BITS] ? (VOLT_BITS+1)'(-dv) : (VOLT_BITS+1)'(dv);
   assign dt  = req.sample_time - last_time_ff;

   uspd_divider #(
      .NUM_BITS (NUM_BITS),
      .DEN_BITS (TIME_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator ({mag, FRAC_BITS'(0)}),
      .divisor   (dt),
      .done      (div_done),
      .quotient  (div_quot)
   );

   assign q_wide = 64'(div_quot);

   // middle slope against its neighbors, then the middle candidate
   assign slope_hit = (slope_fill_ff == 2'd3) && (slope_win_ff[1] > slope_win_ff[0])
                    && (slope_win_ff[1] > slope_ff);
   assign cand_emit = slope_hit && (cand_fill_ff == 2'd2)
                    && (cand_win_ff[1] > cand_win_ff[0])
                    && (cand_win_ff[1] > slope_win_ff[1])
                    && (cand_win_ff[1] > SLOPE_BITS'(0));
   assign out_blocked = rsp_valid_ff && !rsp.ready;

   always_comb begin
      state_in      = state_ff;
      last_time_in  = last_time_ff;
      last_pot_in   = last_pot_ff;
      t_in          = t_ff;
      v_in          = v_ff;
      neg_in        = neg_ff;
      maxed_in      = maxed_ff;
      slope_in      = slope_ff;
      slope_win_in  = slope_win_ff;
      slope_tw_in   = slope_tw_ff;
      slope_fill_in = slope_fill_ff;
      cand_win_in   = cand_win_ff;
      cand_tw_in    = cand_tw_ff;
      cand_fill_in  = cand_fill_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_slope_in  = rsp_slope_ff;
      rsp_time_in   = rsp_time_ff;
      div_start     = 1'b0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (slope_fill_ff == 2'd0) begin
                  // first sample: nothing to compare against yet
                  last_time_in  = req.sample_time;
                  last_pot_in   = req.potential;
                  slope_fill_in = 2'd1;
               end else begin
                  t_in   = req.sample_time;
                  v_in   = req.potential;
                  neg_in = dv[VOLT_BITS];
                  if (req.sample_time <= last_time_ff) begin
                     maxed_in = 1'b1;
                     state_in = ST_FIN;
                  end else begin
                     maxed_in  = 1'b0;
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (maxed_ff) begin
               slope_in = SLOPE_MAX;
            end else if (neg_ff) begin
               slope_in = (q_wide > NEG_LIMIT) ? SLOPE_MIN : slope_type'(-q_wide);
            end else begin
               slope_in = (q_wide > POS_LIMIT) ? SLOPE_MAX : slope_type'(q_wide);
            end
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // hold while a new peak would overwrite one not yet taken
            if (!(cand_emit && out_blocked)) begin
               if (cand_emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_slope_in = cand_win_ff[1];
                  rsp_time_in  = cand_tw_ff[1];
               end
               if (slope_hit) begin
                  cand_win_in[0] = cand_win_ff[1];
                  cand_tw_in[0]  = cand_tw_ff[1];
                  cand_win_in[1] = slope_win_ff[1];
                  cand_tw_in[1]  = slope_tw_ff[1];
                  if (cand_fill_ff != 2'd2) begin
                     cand_fill_in = cand_fill_ff + 2'd1;
                  end
               end
               slope_win_in[0] = slope_win_ff[1];
               slope_tw_in[0]  = slope_tw_ff[1];
               slope_win_in[1] = slope_ff;
               slope_tw_in[1]  = peak_time_type'(64'(last_time_ff));
               if (slope_fill_ff != 2'd3) begin
                  slope_fill_in = slope_fill_ff + 2'd1;
               end
               last_time_in = t_ff;
               last_pot_in  = v_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slope_fill_ff <= '0;
         cand_fill_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slope_fill_ff <= slope_fill_in;
         cand_fill_ff  <= cand_fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      last_time_ff <= last_time_in;
      last_pot_ff  <= last_pot_in;
      t_ff         <= t_in;
      v_ff         <= v_in;
      neg_ff       <= neg_in;
      maxed_ff     <= maxed_in;
      slope_ff     <= slope_in;
      slope_win_ff <= slope_win_in;
      slope_tw_ff  <= slope_tw_in;
      cand_win_ff  <= cand_win_in;
      cand_tw_ff   <= cand_tw_in;
      rsp_slope_ff <= rsp_slope_in;
      rsp_time_ff  <= rsp_time_in;
   end

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.peak_slope = rsp_slope_ff;
   assign rsp.peak_time  = rsp_time_ff;

`ifndef SYNTHESIS
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_peak_from_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EVAL)
      else $error("peak item raised outside evaluation");

   a_fill_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> slope_fill_ff >= $past(slope_fill_ff))
      else $error("slope fill count went backward");

   a_cand_needs_slopes: assert property (@(posedge clock) disable iff (reset)
      cand_fill_ff != 2'd0 |-> slope_fill_ff == 2'd3)
      else $error("candidate held before the slope window filled");
`endif

endmodule

// ===== hdl/uspd_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module uspd_divider
   import uspd_pkg::*;
#(
   parameter int NUM_BITS = 25,
   parameter int DEN_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numerator,
   input  logic [DEN_BITS-1:0] divisor,
   output logic                done,
   output logic [NUM_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [DEN_BITS:0]   trial;
   logic [DEN_BITS:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, num_ff[NUM_BITS-1]};
      diff    = trial - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(NUM_BITS);
         num_in  = numerator;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // no borrow means the divisor fits: take the difference, shift in a one
         if (!diff[DEN_BITS]) begin
            rem_in = diff[DEN_BITS-1:0];
            num_in = {num_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_BITS-1:0];
            num_in = {num_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule
